[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must hold whenever a qualifier is true.
`define ASSERT_WHEN(lbl, clk, rstn, qual, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (qual) |-> (cond)) else $error(msg);

`endif

[rtl/core/exlex_pkg.sv]
// Types, token codes and character classes of the expression lexer.
// No dependencies; used by expression_lexer_top and its checker.
package exlex_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [6:0] token_length;
    logic       last_of_item;
  } out_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  localparam logic [3:0] TK_IDENT   = 4'd0;
  localparam logic [3:0] TK_NUMBER  = 4'd1;
  localparam logic [3:0] TK_PRINT   = 4'd2;
  localparam logic [3:0] TK_PLUS    = 4'd3;
  localparam logic [3:0] TK_MINUS   = 4'd4;
  localparam logic [3:0] TK_TIMES   = 4'd5;
  localparam logic [3:0] TK_SLASH   = 4'd6;
  localparam logic [3:0] TK_LPAREN  = 4'd7;
  localparam logic [3:0] TK_RPAREN  = 4'd8;
  localparam logic [3:0] TK_SEMI    = 4'd9;
  localparam logic [3:0] TK_PERIOD  = 4'd10;
  localparam logic [3:0] TK_END     = 4'd11;
  localparam logic [3:0] TK_BADCHAR = 4'd12;
  localparam logic [3:0] TK_TOOLONG = 4'd13;

  localparam logic [3:0] TK_NONE    = 4'd0;
  localparam logic [2:0] KW_LEN     = 3'd5;

  function automatic logic is_letter(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
  endfunction

  // Operator or punctuation code, TK_NONE when the byte is neither.
  function automatic logic [3:0] punct_kind(input logic [7:0] ch);
    logic [3:0] k;
    case (ch)
      8'h2B:   k = TK_PLUS;
      8'h2D:   k = TK_MINUS;
      8'h2A:   k = TK_TIMES;
      8'h2F:   k = TK_SLASH;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h3B:   k = TK_SEMI;
      8'h2E:   k = TK_PERIOD;
      default: k = TK_NONE;
    endcase
    return k;
  endfunction

  // Character of the keyword "print" at a given position.
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h70;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6E;
      3'd4:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/expression_lexer_top.sv]
// Expression lexer top level: scan state, token decode and a four-entry result queue.
// Depends on exlex_pkg.
//
//   channel | direction | ports                          | payload
//   --------+-----------+--------------------------------+------------------
//   in      | input     | in_valid, in_stall, in_data    | exlex_pkg::in_t
//   out     | output    | out_valid, out_stall, out_data | exlex_pkg::out_t
//
// One byte is taken per cycle while in_stall is low; its tokens are decoded in the
// same cycle and written into the result queue, which presents one token per cycle
// while out_stall is low. A byte can yield two tokens, so the input stalls while
// fewer than two queue entries are free.
// Reset (rst_n low, synchronous) returns to between tokens and empties the queue.
// After an error token every byte is taken and dropped until reset.
module expression_lexer_top #(
  parameter int MAX_LEXEME = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  exlex_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output exlex_pkg::out_t out_data
);

  localparam int LEN_W = $clog2(MAX_LEXEME + 1);
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  exlex_pkg::mode_t mode_r, mode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [2:0]       km_r, km_nxt;
  logic             miss_r, miss_nxt;
  logic             halt_r, halt_nxt;

  exlex_pkg::out_t  q_mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    cnt_r;

  logic             accept, pop;
  logic [7:0]       ch;
  logic             eoi, in_word, cont;
  logic [LEN_W-1:0] len_inc;
  logic             too_long;
  logic [3:0]       pk;
  exlex_pkg::out_t  res0, res1;
  logic [1:0]       n_res;

  assign ch      = in_data.char_byte;
  assign eoi     = in_data.end_of_input;
  assign accept  = in_valid && !in_stall;
  assign pop     = out_valid && !out_stall;
  assign in_word = (mode_r == exlex_pkg::MODE_IDENT) || (mode_r == exlex_pkg::MODE_NUMBER);
  assign cont    = !eoi && ((mode_r == exlex_pkg::MODE_IDENT)
                   ? (exlex_pkg::is_letter(ch) || exlex_pkg::is_digit(ch) || ch == 8'h5F)
                   : exlex_pkg::is_digit(ch));
  assign len_inc  = len_r + LEN_W'(1);
  assign too_long = len_inc >= LEN_W'(MAX_LEXEME);
  assign pk       = exlex_pkg::punct_kind(ch);

  // Next scan state.
  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    km_nxt   = km_r;
    miss_nxt = miss_r;
    halt_nxt = halt_r;
    if (!halt_r) begin
      if (in_word && cont) begin
        if (too_long) begin
          halt_nxt = 1'b1;
          mode_nxt = exlex_pkg::MODE_IDLE;
          len_nxt  = '0;
        end else begin
          len_nxt = len_inc;
          if (mode_r == exlex_pkg::MODE_IDENT) begin
            if (!miss_r && km_r < exlex_pkg::KW_LEN && ch == exlex_pkg::kw_char(km_r)) begin
              km_nxt = km_r + 3'd1;
            end else begin
              miss_nxt = 1'b1;
            end
          end
        end
      end else begin
        // The word in progress, if any, ends here; then the byte starts afresh.
        mode_nxt = exlex_pkg::MODE_IDLE;
        if (in_word) begin
          len_nxt  = '0;
          km_nxt   = '0;
          miss_nxt = 1'b0;
        end
        if (eoi || exlex_pkg::is_space(ch)) begin
          mode_nxt = exlex_pkg::MODE_IDLE;
        end else if (exlex_pkg::is_letter(ch)) begin
          mode_nxt = exlex_pkg::MODE_IDENT;
          len_nxt  = LEN_W'(1);
          km_nxt   = (ch == exlex_pkg::kw_char(3'd0)) ? 3'd1 : 3'd0;
          miss_nxt = ch != exlex_pkg::kw_char(3'd0);
        end else if (exlex_pkg::is_digit(ch)) begin
          mode_nxt = exlex_pkg::MODE_NUMBER;
          len_nxt  = LEN_W'(1);
        end else if (pk == exlex_pkg::TK_NONE) begin
          halt_nxt = 1'b1;
        end
      end
    end
  end

  // Tokens caused by the current byte, in order.
  always_comb begin
    exlex_pkg::out_t word_tok, byte_tok;
    logic            has_word, has_byte;
    word_tok = '0;
    byte_tok = '0;
    has_word = 1'b0;
    has_byte = 1'b0;
    res0     = '0;
    res1     = '0;
    n_res    = 2'd0;
    if (!halt_r) begin
      if (in_word && cont) begin
        if (too_long) begin
          byte_tok.token_kind = exlex_pkg::TK_TOOLONG;
          has_byte = 1'b1;
        end
      end else begin
        if (in_word) begin
          has_word = 1'b1;
          word_tok.token_length = 7'(len_r);
          if (mode_r == exlex_pkg::MODE_NUMBER) begin
            word_tok.token_kind = exlex_pkg::TK_NUMBER;
          end else if (!miss_r && km_r == exlex_pkg::KW_LEN) begin
            word_tok.token_kind = exlex_pkg::TK_PRINT;
          end else begin
            word_tok.token_kind = exlex_pkg::TK_IDENT;
          end
        end
        if (eoi) begin
          has_byte = 1'b1;
          byte_tok.token_kind = exlex_pkg::TK_END;
        end else if (exlex_pkg::is_space(ch) || exlex_pkg::is_letter(ch)
                     || exlex_pkg::is_digit(ch)) begin
          has_byte = 1'b0;
        end else if (pk != exlex_pkg::TK_NONE) begin
          has_byte = 1'b1;
          byte_tok.token_kind   = pk;
          byte_tok.token_length = 7'd1;
        end else begin
          has_byte = 1'b1;
          byte_tok.token_kind = exlex_pkg::TK_BADCHAR;
        end
      end
    end
    byte_tok.last_of_item = 1'b1;
    word_tok.last_of_item = !has_byte;
    if (has_word) begin
      res0  = word_tok;
      res1  = byte_tok;
      n_res = has_byte ? 2'd2 : 2'd1;
    end else if (has_byte) begin
      res0  = byte_tok;
      n_res = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= exlex_pkg::MODE_IDLE;
      len_r  <= '0;
      km_r   <= '0;
      miss_r <= 1'b0;
      halt_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      km_r   <= km_nxt;
      miss_r <= miss_nxt;
      halt_r <= halt_nxt;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      q_mem[wr_ptr_r] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      q_mem[wr_ptr_r + Q_AW'(1)] <= res1;
    end
  end

  logic [Q_AW:0] push_n;
  assign push_n = accept ? (Q_AW + 1)'(n_res) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[Q_AW-1:0];
      rd_ptr_r <= rd_ptr_r + Q_AW'(pop);
      cnt_r    <= cnt_r + push_n - (Q_AW + 1)'(pop);
    end
  end

  assign in_stall  = cnt_r > (Q_AW + 1)'(Q_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_data  = q_mem[rd_ptr_r];

endmodule

[rtl/core/exlex_checker.sv]
// Port-level checker for the expression lexer, bound to expression_lexer_top.
// Depends on exlex_pkg and assert_macros.svh.
`include "assert_macros.svh"

module exlex_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input exlex_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input exlex_pkg::out_t out_data
);

  logic out_xfer, err_tok, zero_len_tok, word_tok;

  assign out_xfer     = out_valid && !out_stall;
  assign err_tok      = out_data.token_kind == exlex_pkg::TK_BADCHAR
                        || out_data.token_kind == exlex_pkg::TK_TOOLONG;
  assign zero_len_tok = err_tok || out_data.token_kind == exlex_pkg::TK_END;
  assign word_tok     = out_data.token_kind == exlex_pkg::TK_IDENT
                        || out_data.token_kind == exlex_pkg::TK_NUMBER
                        || out_data.token_kind == exlex_pkg::TK_PRINT;

  // A stalled result is held until its transfer.
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // Nothing follows an error token until reset.
  `ASSERT_CLK(a_err_silent, clk, rst_n,
    out_xfer && err_tok |=> !out_valid, "result after an error token")

  // End and error tokens are final and carry no length.
  `ASSERT_WHEN(a_zero_len, clk, rst_n, out_valid && zero_len_tok,
    out_data.token_length == 7'd0 && out_data.last_of_item, "bad end or error token")

  // Words carry a length.
  `ASSERT_WHEN(a_word_len, clk, rst_n, out_valid && word_tok,
    out_data.token_length != 7'd0, "word token without length")

endmodule

bind expression_lexer_top exlex_checker u_exlex_checker (.*);

[tb/expression_lexer_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for expression_lexer_top: a token predictor, a directed script and
// random source texts, with random gaps on the input and random stalls on the output.
// Depends on exlex_pkg and expression_lexer_top.
module expression_lexer_top_test;

  localparam int LEX_MAX = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 380;
  localparam int CALM_AFTER = 300;
  localparam int KEYWORD_LEN = 5;
  localparam logic [39:0] KEYWORD = "print";
  localparam logic [1:0] BY_MODEL = 2'd3;
  localparam exlex_pkg::out_t NO_TOK = '0;

  // One script row: a byte sent reps times, with either typed tokens or the predictor's.
  typedef struct packed {
    logic [7:0]      ch;
    logic            eoi;
    logic [6:0]      reps;
    logic [1:0]      ntyped;
    exlex_pkg::out_t t0;
    exlex_pkg::out_t t1;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  exlex_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  exlex_pkg::out_t out_data;

  // Scanner state mirrored by the predictor.
  exlex_pkg::mode_t lex_mode = exlex_pkg::MODE_IDLE;
  int lex_len = 0;
  int kw_hits = 0;
  bit kw_broken = 1'b0;
  bit lex_halted = 1'b0;

  exlex_pkg::out_t step_tokens[$];
  exlex_pkg::out_t pending_tokens[$];
  int errors = 0;
  int cycle_count = 0;
  int work_items = 0;
  int idle_pct = 0;
  bit calm = 1'b0;

  row_t script [30] = '{
    {8'hFF, 1'b1, 7'd1,  2'd1, {exlex_pkg::TK_END, 7'd0, 1'b1}, NO_TOK},
    {" ",   1'b0, 7'd1,  2'd0, NO_TOK, NO_TOK},
    {8'h09, 1'b0, 7'd1,  2'd0, NO_TOK, NO_TOK},
    {8'h0D, 1'b0, 7'd1,  2'd0, NO_TOK, NO_TOK},
    {"p",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"r",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"i",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"n",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"t",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"-",   1'b0, 7'd1,  2'd2, {exlex_pkg::TK_PRINT, 7'd5, 1'b0},
                               {exlex_pkg::TK_MINUS, 7'd1, 1'b1}},
    {"9",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"0",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"Z",   1'b0, 7'd1,  2'd1, {exlex_pkg::TK_NUMBER, 7'd2, 1'b1}, NO_TOK},
    {"_",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"0",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"z",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"(",   1'b0, 7'd1,  2'd2, {exlex_pkg::TK_IDENT, 7'd4, 1'b0},
                               {exlex_pkg::TK_LPAREN, 7'd1, 1'b1}},
    {"+",   1'b0, 7'd1,  2'd1, {exlex_pkg::TK_PLUS, 7'd1, 1'b1}, NO_TOK},
    {"*",   1'b0, 7'd1,  2'd1, {exlex_pkg::TK_TIMES, 7'd1, 1'b1}, NO_TOK},
    {"/",   1'b0, 7'd1,  2'd1, {exlex_pkg::TK_SLASH, 7'd1, 1'b1}, NO_TOK},
    {")",   1'b0, 7'd1,  2'd1, {exlex_pkg::TK_RPAREN, 7'd1, 1'b1}, NO_TOK},
    {";",   1'b0, 7'd1,  2'd1, {exlex_pkg::TK_SEMI, 7'd1, 1'b1}, NO_TOK},
    {".",   1'b0, 7'd1,  2'd1, {exlex_pkg::TK_PERIOD, 7'd1, 1'b1}, NO_TOK},
    {"a",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {"z",   1'b0, 7'd62, BY_MODEL, NO_TOK, NO_TOK},
    {8'h0B, 1'b0, 7'd1,  2'd1, {exlex_pkg::TK_IDENT, 7'd63, 1'b1}, NO_TOK},
    {"1",   1'b0, 7'd63, BY_MODEL, NO_TOK, NO_TOK},
    {"+",   1'b1, 7'd1,  2'd2, {exlex_pkg::TK_NUMBER, 7'd63, 1'b0},
                               {exlex_pkg::TK_END, 7'd0, 1'b1}},
    {"q",   1'b0, 7'd1,  BY_MODEL, NO_TOK, NO_TOK},
    {8'h80, 1'b1, 7'd1,  2'd2, {exlex_pkg::TK_IDENT, 7'd1, 1'b0},
                               {exlex_pkg::TK_END, 7'd0, 1'b1}}
  };

  expression_lexer_top #(
    .MAX_LEXEME(LEX_MAX)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  function automatic bit letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit blank_byte(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [3:0] punct_token(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      "+":     k = exlex_pkg::TK_PLUS;
      "-":     k = exlex_pkg::TK_MINUS;
      "*":     k = exlex_pkg::TK_TIMES;
      "/":     k = exlex_pkg::TK_SLASH;
      "(":     k = exlex_pkg::TK_LPAREN;
      ")":     k = exlex_pkg::TK_RPAREN;
      ";":     k = exlex_pkg::TK_SEMI;
      ".":     k = exlex_pkg::TK_PERIOD;
      default: k = exlex_pkg::TK_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] keyword_byte(input int i);
    return KEYWORD[8 * (KEYWORD_LEN - 1 - i) +: 8];
  endfunction

  function automatic void add_token(input logic [3:0] kind, input int len);
    step_tokens.push_back({kind, 7'(len), 1'b0});
  endfunction

  function automatic void match_keyword(input logic [7:0] c);
    if (!kw_broken && kw_hits < KEYWORD_LEN && c == keyword_byte(kw_hits)) begin
      kw_hits++;
    end else begin
      kw_broken = 1'b1;
    end
  endfunction

  // Advances the scanner by one accepted byte and leaves its tokens in step_tokens.
  function automatic void lex_step(input exlex_pkg::in_t item);
    logic [7:0] c;
    logic eoi;
    bit grows;
    logic [3:0] pk;
    c = item.char_byte;
    eoi = item.end_of_input;
    pk = punct_token(c);
    step_tokens.delete();
    if (lex_halted) return;
    if (lex_mode == exlex_pkg::MODE_IDENT || lex_mode == exlex_pkg::MODE_NUMBER) begin
      grows = !eoi && (digit_byte(c) ||
                       (lex_mode == exlex_pkg::MODE_IDENT && (letter_byte(c) || c == "_")));
      if (grows) begin
        lex_len++;
        if (lex_len >= LEX_MAX) begin
          add_token(exlex_pkg::TK_TOOLONG, 0);
          lex_halted = 1'b1;
          lex_mode = exlex_pkg::MODE_IDLE;
          lex_len = 0;
        end else if (lex_mode == exlex_pkg::MODE_IDENT) begin
          match_keyword(c);
        end
        return;
      end
      if (lex_mode == exlex_pkg::MODE_NUMBER) begin
        add_token(exlex_pkg::TK_NUMBER, lex_len);
      end else if (!kw_broken && kw_hits == KEYWORD_LEN) begin
        add_token(exlex_pkg::TK_PRINT, lex_len);
      end else begin
        add_token(exlex_pkg::TK_IDENT, lex_len);
      end
      lex_len = 0;
      kw_hits = 0;
      kw_broken = 1'b0;
    end
    lex_mode = exlex_pkg::MODE_IDLE;
    if (eoi) begin
      add_token(exlex_pkg::TK_END, 0);
    end else if (blank_byte(c)) begin
      return;
    end else if (letter_byte(c)) begin
      lex_mode = exlex_pkg::MODE_IDENT;
      lex_len = 1;
      kw_hits = 0;
      kw_broken = 1'b0;
      match_keyword(c);
    end else if (digit_byte(c)) begin
      lex_mode = exlex_pkg::MODE_NUMBER;
      lex_len = 1;
    end else if (pk != exlex_pkg::TK_NONE) begin
      add_token(pk, 1);
    end else begin
      add_token(exlex_pkg::TK_BADCHAR, 0);
      lex_halted = 1'b1;
    end
  endfunction

  // Drives one byte from a falling edge and returns at the falling edge after its transfer.
  task automatic send_item(input exlex_pkg::in_t item, input logic [1:0] ntyped,
                           input exlex_pkg::out_t t0, input exlex_pkg::out_t t1);
    exlex_pkg::out_t tok;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_step(item);
    if (ntyped == BY_MODEL) begin
      foreach (step_tokens[i]) begin
        tok = step_tokens[i];
        tok.last_of_item = (i == step_tokens.size() - 1);
        pending_tokens.push_back(tok);
      end
    end else begin
      if (ntyped > 0) pending_tokens.push_back(t0);
      if (ntyped > 1) pending_tokens.push_back(t1);
    end
    work_items++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c, input logic eoi);
    send_item({c, eoi}, BY_MODEL, NO_TOK, NO_TOK);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'(8'h61 + $urandom_range(0, 25))
                                : 8'(8'h41 + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0, 1:    c = rand_letter();
      2:       c = 8'(8'h30 + $urandom_range(0, 9));
      default: c = "_";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    int v;
    v = $urandom_range(8, 13);
    return (v == 8) ? " " : 8'(v);
  endfunction

  function automatic logic [7:0] rand_punct();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0:       c = "+";
      1:       c = "-";
      2:       c = "*";
      3:       c = "/";
      4:       c = "(";
      5:       c = ")";
      6:       c = ";";
      default: c = ".";
    endcase
    return c;
  endfunction

  function automatic int rand_word_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, LEX_MAX - 1)
                                        : $urandom_range(1, 8);
  endfunction

  // Words end at a separator or at end of input, so two words never merge past the limit.
  task automatic send_separator();
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 2)) send_char(rand_blank(), 1'b0);
    end else begin
      send_char(rand_punct(), 1'b0);
    end
  endtask

  // One source text: words, keywords, numbers, operators and blanks, then end of input,
  // which may cut off the last word.
  task automatic send_random_text();
    int pieces;
    int len;
    pieces = $urandom_range(1, 12);
    if (!calm) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = rand_word_len();
          send_char(rand_letter(), 1'b0);
          repeat (len - 1) send_char(rand_word_char(), 1'b0);
          if (p != pieces - 1) send_separator();
        end
        3: begin
          len = $urandom_range(0, 1) ? KEYWORD_LEN : $urandom_range(1, KEYWORD_LEN);
          for (int i = 0; i < len; i++) send_char(keyword_byte(i), 1'b0);
          if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3))
            send_char(rand_word_char(), 1'b0);
          if (p != pieces - 1) send_separator();
        end
        4, 5: begin
          len = rand_word_len();
          repeat (len) send_char(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
          if (p != pieces - 1) send_separator();
        end
        8: repeat ($urandom_range(1, 3)) send_char(rand_blank(), 1'b0);
        default: send_char(rand_punct(), 1'b0);
      endcase
    end
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin : stimulus
    logic [7:0] c;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    idle_pct = 25;
    foreach (script[r]) begin
      repeat (script[r].reps)
        send_item({script[r].ch, script[r].eoi}, script[r].ntyped, script[r].t0, script[r].t1);
    end

    // Let the result side drain completely before the random texts.
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    @(negedge clk);

    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      if (work_items >= CALM_AFTER) begin
        calm = 1'b1;
        idle_pct = 0;
      end
      send_random_text();
    end

    // Only one fatal error can be seen per run, since the block stays halted until reset.
    if ($urandom_range(0, 1)) begin
      send_char(rand_letter(), 1'b0);
      repeat (LEX_MAX - 1) send_char(rand_word_char(), 1'b0);
    end else begin
      if ($urandom_range(0, 1)) send_char(rand_letter(), 1'b0);
      c = 8'($urandom_range(0, 255));
      while (letter_byte(c) || digit_byte(c) || blank_byte(c)
             || punct_token(c) != exlex_pkg::TK_NONE)
        c = 8'($urandom_range(0, 255));
      send_char(c, 1'b0);
    end
    repeat (20) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("expression_lexer_top_test: clean");
    end else begin
      $display("expression_lexer_top_test: errors");
    end
    $finish;
  end

  always begin
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 17)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_tokens
    exlex_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        errors++;
        $display("%0t: expected no token, got kind %0d length %0d last %0d", $time,
                 out_data.token_kind, out_data.token_length, out_data.last_of_item);
      end else begin
        want = pending_tokens.pop_front();
        if (out_data.token_kind !== want.token_kind ||
            out_data.token_length !== want.token_length ||
            out_data.last_of_item !== want.last_of_item) begin
          errors++;
          $display("%0t: expected kind %0d length %0d last %0d, got kind %0d length %0d last %0d",
                   $time, want.token_kind, want.token_length, want.last_of_item,
                   out_data.token_kind, out_data.token_length, out_data.last_of_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("expression_lexer_top_test: errors");
      $finish;
    end
  end

endmodule
